FILE: hdl/dqi_pkg.sv
// ----------------------------------------------------------------------------
// dqi_pkg
// shared types and constants for the bounded indexed deque
// ----------------------------------------------------------------------------
package dqi_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int REQ_W    = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    // request codes, 6 and 7 are unused
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ       = 3'd4,
        REQ_CLEAR      = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // per-cell control
    typedef struct packed {
        logic shift_r;  // take the value of the left neighbour
        logic shift_l;  // take the value of the right neighbour
        logic load;     // take the pushed value
    } cell_ctrl_t;

endpackage

FILE: hdl/dqi_cell.sv
// ----------------------------------------------------------------------------
// dqi_cell
// one storage cell of the deque row, shifts towards either neighbour
// ----------------------------------------------------------------------------
module dqi_cell #(
    parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  dqi_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  load_data,
    output logic [DATA_WIDTH-1:0]  data
);
    import dqi_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift_r)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_l)
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hdl/bounded_deque_indexed_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_indexed_unit
// bounded double-ended queue held as a row of shifting cells
// ----------------------------------------------------------------------------
// The deque takes one transaction per clock cycle: busy never rises, and the
// result of a transaction accepted at one edge is on the result ports, marked
// by done, for the single following cycle. Elements sit in a row of DEPTH
// cells in logical order, front in cell 0; push front and pop front move the
// whole row one cell, push back loads the cell at the count, pop back only
// lowers the count, and read at index selects one cell through a DEPTH-way
// mux, which with the row shift sets the cycle time. The element store needs
// no clearing after reset; only the count, done and status are reset.
// ----------------------------------------------------------------------------
module bounded_deque_indexed_unit #(
    parameter int DEPTH      = dqi_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dqi_pkg::REQ_W-1:0]     req_type,
    input  logic [DATA_WIDTH-1:0]         push_value,
    input  logic [dqi_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic [DATA_WIDTH-1:0]         read_data,
    output logic [dqi_pkg::STATUS_W-1:0]  status,
    output logic [$clog2(DEPTH+1)-1:0]    element_count,
    output logic                          is_empty
);
    import dqi_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // element count, the only control state of the row
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // result registers
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;
    logic [DATA_WIDTH-1:0] read_data_next;
    status_t               status_reg;
    status_t               status_next;

    // row controls
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  row_shift_r;
    logic                  row_shift_l;
    logic                  tail_load_en;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      cnt_cmp;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pos_cmp = CMP_W'(position);
    assign cnt_cmp = CMP_W'(count_reg);

    // request decode
    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_OK;
        read_data_next = '0;
        row_shift_r    = 1'b0;
        row_shift_l    = 1'b0;
        tail_load_en   = 1'b0;

        if (accept)
        begin
            unique case (req_t'(req_type))
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        tail_load_en = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // whole row moves back, cell 0 takes the new value
                        row_shift_r = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        row_shift_l = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                REQ_READ:
                begin
                    if (pos_cmp >= cnt_cmp)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        read_data_next = cell_data[pos_cmp[IDX_W-1:0]];
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // unused codes leave the queue alone
                end
            endcase
        end
    end

    // row of cells, front element in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t            ctrl;
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        assign ctrl.shift_r = row_shift_r;
        assign ctrl.shift_l = row_shift_l;
        assign ctrl.load    = tail_load_en && (count_reg[IDX_W-1:0] == IDX_W'(i));

        if (i == 0)
        begin : g_first
            assign left_d = push_value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        dqi_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (push_value),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    // read data is payload
    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign done          = done_reg;
    assign read_data     = read_data_reg;
    assign status        = status_reg;
    assign element_count = count_reg;
    assign is_empty      = (count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction gave no result");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (element_count == CNT_W'(DEPTH)))
        else $error("push on full reported below depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_CLEAR) |=> is_empty)
        else $error("clear left elements behind");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_data == '0))
        else $error("failed transaction returned data");
`endif

endmodule
